[design/cfam_pkg.sv]
// Package for the custom float add/multiply unit.
// Holds format constants and status codes; no dependencies.
package cfam_pkg;
  localparam int unsigned FracBits = 18;
  localparam int unsigned ExpBits  = 17;
  localparam int unsigned ExpBias  = 30000;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StOverflow  = 2'd1,
    StUnderflow = 2'd2
  } status_e;
endpackage

[design/custom_float_add_multiply.sv]
// Custom float adder/multiplier: sign, EXP_BITS exponent, FRAC_BITS fraction.
// A start transfer passes through stages 1, 2 and 3 and the output register to done_o; one operation per cycle.
// busy is always low: the receiver cannot stall, so nothing holds the pipe.
// Reset (rst_ni low, async) clears only the stage valid bits.
// Depends on cfam_pkg and cfam_mul.
module custom_float_add_multiply #(
  parameter int unsigned FRAC_BITS = cfam_pkg::FracBits,
  parameter int unsigned EXP_BITS  = cfam_pkg::ExpBits,
  parameter int unsigned EXP_BIAS  = cfam_pkg::ExpBias
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func_i,
  input  logic                 a_sign_i,
  input  logic [EXP_BITS-1:0]  a_exp_i,
  input  logic [FRAC_BITS-1:0] a_frac_i,
  input  logic                 b_sign_i,
  input  logic [EXP_BITS-1:0]  b_exp_i,
  input  logic [FRAC_BITS-1:0] b_frac_i,
  output logic                 done_o,
  output logic                 r_sign_o,
  output logic [EXP_BITS-1:0]  r_exp_o,
  output logic [FRAC_BITS-1:0] r_frac_o,
  output logic [1:0]           status_o
);
  import cfam_pkg::*;
  localparam int unsigned SW = FRAC_BITS + 1;
  // signed working exponent, wide enough for the sum of two exponents minus the bias
  localparam int unsigned EW = (EXP_BITS > 19) ? EXP_BITS + 3 : 22;
  localparam int unsigned DW = EXP_BITS;
  localparam int unsigned LZW = $clog2(SW + 1);
  localparam logic signed [EW-1:0] EMAX = EW'((1 << EXP_BITS) - 1);

  assign busy = 1'b0;

  // ---------------- stage 1: order, diff, mul exponent
  logic v1_q, f1_q, xs1_q, ys1_q;
  logic [SW-1:0] sx1_q, sy1_q;
  logic [DW-1:0] d1_q;
  logic signed [EW-1:0] e1_q;
  logic [SW-1:0] ma_q, mb_q;

  logic a_big;
  assign a_big = (a_exp_i > b_exp_i) || (a_exp_i == b_exp_i && a_frac_i >= b_frac_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end

  always_ff @(posedge clk_i) begin
    f1_q  <= func_i;
    ma_q  <= {1'b1, a_frac_i};
    mb_q  <= {1'b1, b_frac_i};
    if (func_i) begin
      xs1_q <= a_sign_i ^ b_sign_i;
      ys1_q <= 1'b0;
      sx1_q <= '0;
      sy1_q <= '0;
      d1_q  <= '0;
      e1_q  <= EW'(a_exp_i) + EW'(b_exp_i) - EW'(EXP_BIAS);
    end else if (a_big) begin
      xs1_q <= a_sign_i; ys1_q <= b_sign_i;
      sx1_q <= {1'b1, a_frac_i}; sy1_q <= {1'b1, b_frac_i};
      d1_q  <= a_exp_i - b_exp_i;
      e1_q  <= EW'(a_exp_i);
    end else begin
      xs1_q <= b_sign_i; ys1_q <= a_sign_i;
      sx1_q <= {1'b1, b_frac_i}; sy1_q <= {1'b1, a_frac_i};
      d1_q  <= b_exp_i - a_exp_i;
      e1_q  <= EW'(b_exp_i);
    end
  end

  // multiplier spans stages 2 and 3
  logic [2*SW-1:0] prod;
  cfam_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i(clk_i), .a_i(ma_q), .b_i(mb_q), .p_o(prod)
  );

  // ---------------- stage 2: align and add/sub
  logic v2_q, f2_q, s2_sign_q, eff_sub2_q;
  logic [SW:0] s2_q;
  logic signed [EW-1:0] e2_q;
  logic [SW-1:0] sy_al;
  assign sy_al = (32'(d1_q) >= 32'(SW)) ? '0 : (sy1_q >> d1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    f2_q       <= f1_q;
    s2_sign_q  <= xs1_q;
    eff_sub2_q <= xs1_q ^ ys1_q;
    e2_q       <= e1_q;
    s2_q       <= (xs1_q == ys1_q) ? ({1'b0, sx1_q} + {1'b0, sy_al})
                                   : ({1'b0, sx1_q} - {1'b0, sy_al});
  end

  // ---------------- stage 3: leading-zero count, mul normalize
  logic v3_q, f3_q, sign3_q, zero3_q, sub3_q;
  logic [SW:0] s3_q;
  logic [LZW-1:0] lz3_q;
  logic signed [EW-1:0] e3_q;
  logic [FRAC_BITS-1:0] mf3_q;

  logic [LZW-1:0] lz;
  always_comb begin
    lz = LZW'(SW);
    for (int i = 0; i < SW; i++) begin
      if (s2_q[i]) lz = LZW'(SW - 1 - i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    f3_q    <= f2_q;
    sign3_q <= s2_sign_q;
    sub3_q  <= eff_sub2_q;
    zero3_q <= eff_sub2_q && (s2_q == '0);
    s3_q    <= s2_q;
    lz3_q   <= lz;
    mf3_q   <= prod[2*SW-3 -: FRAC_BITS];
    e3_q    <= e2_q;
    // product bump applies only to multiplies
    if (f2_q && prod[2*SW-1]) begin
      mf3_q <= prod[2*SW-2 -: FRAC_BITS];
      e3_q  <= e2_q + EW'(1);
    end
  end

  // ---------------- stage 4: shift, pack
  logic [SW:0] sh;
  logic signed [EW-1:0] en;
  logic [FRAC_BITS-1:0] fn;
  always_comb begin
    sh = s3_q;
    en = e3_q;
    if (f3_q) begin
      fn = mf3_q;
    end else if (!sub3_q && s3_q[SW]) begin
      fn = s3_q[SW-1:1];
      en = e3_q + EW'(1);
    end else if (sub3_q) begin
      sh = s3_q << lz3_q;
      fn = sh[FRAC_BITS-1:0];
      en = e3_q - EW'(lz3_q);
    end else begin
      fn = s3_q[FRAC_BITS-1:0];
    end
  end

  logic done_q, sign_q;
  logic [EXP_BITS-1:0] exp_q;
  logic [FRAC_BITS-1:0] frac_q;
  status_e st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign3_q;
    if (!f3_q && zero3_q) begin
      sign_q <= 1'b0; exp_q <= '0; frac_q <= '0; st_q <= StUnderflow;
    end else if (en > EMAX) begin
      exp_q <= '1; frac_q <= '1; st_q <= StOverflow;
    end else if (en < 0) begin
      exp_q <= '0; frac_q <= '0; st_q <= StUnderflow;
    end else begin
      exp_q <= en[EXP_BITS-1:0]; frac_q <= fn; st_q <= StOk;
    end
  end

  assign done_o   = done_q;
  assign r_sign_o = sign_q;
  assign r_exp_o  = exp_q;
  assign r_frac_o = frac_q;
  assign status_o = st_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##4 done_o) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 4)) else $error("spurious result");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o != 2'd3)) else $error("bad status");
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StOverflow) |-> (r_exp_o == '1 && r_frac_o == '1))
    else $error("overflow not saturated");
`endif
endmodule

[design/cfam_mul.sv]
// Significand multiplier for the float unit, split over two stages.
// Depends on cfam_pkg for format defaults.
module cfam_mul #(
  parameter int unsigned FRAC_BITS = cfam_pkg::FracBits
) (
  input  logic                       clk_i,
  input  logic [FRAC_BITS:0]         a_i,
  input  logic [FRAC_BITS:0]         b_i,
  output logic [2*FRAC_BITS+1:0]     p_o
);
  import cfam_pkg::*;
  localparam int unsigned SW = FRAC_BITS + 1;
  localparam int unsigned HW = SW / 2;
  localparam int unsigned LW = SW - HW;

  // b split into a low and high part; partial products registered, summed next stage
  logic [SW+LW-1:0] pl_q;
  logic [SW+HW-1:0] ph_q;

  always_ff @(posedge clk_i) begin
    pl_q <= (SW+LW)'(a_i) * (SW+LW)'(b_i[LW-1:0]);
    ph_q <= (SW+HW)'(a_i) * (SW+HW)'(b_i[SW-1:LW]);
  end

  assign p_o = (2*SW)'(pl_q) + ((2*SW)'(ph_q) << LW);
endmodule
